// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER_CLK(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// File: hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_WORDS = 4;

   typedef enum logic [3:0] {
      ST_DATA      = 4'd0,
      ST_DONE      = 4'd1,
      ST_UNTERM    = 4'd2,
      ST_CONTROL   = 4'd3,
      ST_OPEN_ESC  = 4'd4,
      ST_OPEN_UNI  = 4'd5,
      ST_BAD_HEX   = 4'd6,
      ST_NO_LOW    = 4'd7,
      ST_BAD_LOW   = 4'd8,
      ST_STRAY_LOW = 4'd9,
      ST_BAD_ESC   = 4'd10
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_req;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [3:0] status;
      logic       last;
   } rsp_type;

   // All words caused by one input word; count is 1 to MAX_WORDS when queued.
   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
      logic            byte_valid;
      status_type      status;
   } grp_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic    valid;
      grp_type grp;
   } head_type;

endpackage

// File: hw/rtl/jsu_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jsu_front
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output logic    push,
   output grp_type push_grp
);

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_BODY   = 7'b0000010,
      PH_ESC    = 7'b0000100,
      PH_HEX1   = 7'b0001000,
      PH_WANTBS = 7'b0010000,
      PH_WANTU  = 7'b0100000,
      PH_HEX2   = 7'b1000000
   } phase_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [15:0] HI_LO   = 16'hD800;
   localparam logic [15:0] HI_HI   = 16'hDBFF;
   localparam logic [15:0] LO_LO   = 16'hDC00;
   localparam logic [15:0] LO_HI   = 16'hDFFF;
   localparam logic [20:0] CP_1MAX = 21'h00007F;
   localparam logic [20:0] CP_2MAX = 21'h0007FF;
   localparam logic [20:0] CP_3MAX = 21'h00FFFF;
   localparam logic [20:0] CP_SUPP = 21'h010000;

   phase_type   phase_ff, phase_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0]  seen_ff, seen_in;
   logic [9:0]  high_ff, high_in;
   grp_type     grp;
   logic        accept;
   logic [4:0]  digit;
   logic [15:0] val;
   logic [20:0] cp_pair;

   function automatic grp_type report(input status_type s);
      grp_type g;
      g        = '0;
      g.count  = 3'd1;
      g.status = s;
      return g;
   endfunction

   function automatic grp_type one_byte(input logic [7:0] b);
      grp_type g;
      g            = '0;
      g.count      = 3'd1;
      g.bytes[0]   = b;
      g.byte_valid = 1'b1;
      g.status     = ST_DATA;
      return g;
   endfunction

   function automatic grp_type utf8_group(input logic [20:0] cp);
      grp_type g;
      g            = '0;
      g.byte_valid = 1'b1;
      g.status     = ST_DATA;
      if (cp <= CP_1MAX) begin
         g.count    = 3'd1;
         g.bytes[0] = cp[7:0];
      end else if (cp <= CP_2MAX) begin
         g.count    = 3'd2;
         g.bytes[0] = {3'b110, cp[10:6]};
         g.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= CP_3MAX) begin
         g.count    = 3'd3;
         g.bytes[0] = {4'b1110, cp[15:12]};
         g.bytes[1] = {2'b10, cp[11:6]};
         g.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         g.count    = 3'd4;
         g.bytes[0] = {5'b11110, cp[20:18]};
         g.bytes[1] = {2'b10, cp[17:12]};
         g.bytes[2] = {2'b10, cp[11:6]};
         g.bytes[3] = {2'b10, cp[5:0]};
      end
      return g;
   endfunction

   // Digit value, or 16 for a byte that is no hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] d;
      d = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) d = {1'b0, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         d = {1'b0, c[3:0]} + 5'd9;
      return d;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign digit     = hex_value(req_data.in_byte);
   assign val       = {accum_ff[11:0], digit[3:0]};
   assign cp_pair   = CP_SUPP + {1'b0, high_ff, val[9:0]};

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      seen_in  = seen_ff;
      high_in  = high_ff;
      grp      = '0;
      if (req_data.end_of_input) begin
         phase_in = PH_IDLE;
         case (phase_ff)
            PH_BODY:   grp = report(ST_UNTERM);
            PH_ESC:    grp = report(ST_OPEN_ESC);
            PH_HEX1:   grp = report(ST_OPEN_UNI);
            PH_HEX2:   grp = report(ST_OPEN_UNI);
            PH_WANTBS: grp = report(ST_NO_LOW);
            PH_WANTU:  grp = report(ST_NO_LOW);
            default:   grp = '0;
         endcase
      end else if (req_data.start_req) begin
         phase_in = PH_BODY;
         accum_in = '0;
         seen_in  = '0;
         high_in  = '0;
      end else begin
         case (phase_ff)
            PH_BODY: begin
               if (req_data.in_byte == CH_QUOTE) begin
                  grp      = report(ST_DONE);
                  phase_in = PH_IDLE;
               end else if (req_data.in_byte < CH_SPACE) begin
                  grp      = report(ST_CONTROL);
                  phase_in = PH_IDLE;
               end else if (req_data.in_byte == CH_BSL) begin
                  phase_in = PH_ESC;
               end else begin
                  grp = one_byte(req_data.in_byte);
               end
            end
            PH_ESC: begin
               phase_in = PH_BODY;
               case (req_data.in_byte)
                  CH_QUOTE: grp = one_byte(CH_QUOTE);
                  CH_BSL:   grp = one_byte(CH_BSL);
                  CH_SLASH: grp = one_byte(CH_SLASH);
                  CH_B:     grp = one_byte(8'h08);
                  CH_F:     grp = one_byte(8'h0C);
                  CH_N:     grp = one_byte(8'h0A);
                  CH_R:     grp = one_byte(8'h0D);
                  CH_T:     grp = one_byte(8'h09);
                  CH_U: begin
                     phase_in = PH_HEX1;
                     accum_in = '0;
                     seen_in  = '0;
                  end
                  default: begin
                     grp      = report(ST_BAD_ESC);
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            PH_WANTBS: begin
               if (req_data.in_byte != CH_BSL) begin
                  grp      = report(ST_NO_LOW);
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_WANTU;
               end
            end
            PH_WANTU: begin
               if (req_data.in_byte != CH_U) begin
                  grp      = report(ST_NO_LOW);
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_HEX2;
                  accum_in = '0;
                  seen_in  = '0;
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (digit[4]) begin
                  grp      = report(ST_BAD_HEX);
                  phase_in = PH_IDLE;
               end else begin
                  accum_in = val;
                  if (seen_ff != 2'd3) begin
                     seen_in = seen_ff + 2'd1;
                  end else begin
                     seen_in = '0;
                     if (phase_ff == PH_HEX1) begin
                        if (val >= HI_LO && val <= HI_HI) begin
                           high_in  = val[9:0];
                           phase_in = PH_WANTBS;
                        end else if (val >= LO_LO && val <= LO_HI) begin
                           grp      = report(ST_STRAY_LOW);
                           phase_in = PH_IDLE;
                        end else begin
                           grp      = utf8_group({5'd0, val});
                           phase_in = PH_BODY;
                        end
                     end else if (val < LO_LO || val > LO_HI) begin
                        grp      = report(ST_BAD_LOW);
                        phase_in = PH_IDLE;
                     end else begin
                        grp      = utf8_group(cp_pair);
                        phase_in = PH_BODY;
                     end
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   assign push     = accept && (grp.count != 3'd0);
   assign push_grp = grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         accum_ff <= '0;
         seen_ff  <= '0;
         high_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         seen_ff  <= seen_in;
         high_ff  <= high_in;
      end
   end

   `ASSERT_NEVER_CLK(a_group_size, clock, reset, push && (grp.count > 3'd4))
   `ASSERT_CLK(a_hex_count, clock, reset,
      (phase_ff != PH_HEX1 && phase_ff != PH_HEX2 && phase_ff != PH_IDLE) |-> (seen_ff == 2'd0))

endmodule

// File: hw/rtl/jsu_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  grp_type  push_grp,
   output logic     full,
   input  logic     pop,
   output head_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

   grp_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_pop;

   assign full       = (cnt_ff == FULL_CNT);
   assign head.valid = (cnt_ff != '0);
   assign head.grp   = slot_ff[rd_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + 1'b1;
      if (do_pop) rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + 1'b1;
      if (push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // hold payload in place; no reset needed
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_grp;
   end

   `ASSERT_NEVER_CLK(a_no_overflow, clock, reset, push && full)
   `ASSERT_CLK(a_count_range, clock, reset, cnt_ff <= FULL_CNT)

endmodule

// File: hw/rtl/jsu_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jsu_back
   import jsu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       at_end;

   assign load   = !rsp_valid_ff || !rsp_stall;
   assign at_end = ({1'b0, idx_ff} == (head.grp.count - 3'd1));
   assign pop    = load && head.valid && at_end;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = head.valid;
         if (head.valid) begin
            rsp_in.out_byte   = head.grp.bytes[idx_ff];
            rsp_in.byte_valid = head.grp.byte_valid;
            rsp_in.status     = head.grp.status;
            rsp_in.last       = at_end;
            // advance through the group, restart on its last word
            idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_CLK(a_idx_in_group, clock, reset,
      head.valid |-> ({1'b0, idx_ff} < head.grp.count))
   `ASSERT_CLK(a_idx_idle, clock, reset, !head.valid |-> (idx_ff == 2'd0))

endmodule

// File: hw/rtl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// JSON string body decoder with UTF-8 output.
// Request channel (req_valid / req_stall / req_data): one word per text byte,
// with start_req marking the opening quote and end_of_input marking the end
// of the text. Response channel (rsp_valid / rsp_stall / rsp_data): decoded
// UTF-8 bytes with status 0, or a single status word with byte_valid low for
// completion or the first error; last is set on the final word of each input.
// A word is taken on a rising edge with valid high and stall low.
// The first response word of an input passes through a queue slot and then
// the output register before it is valid. Throughput: one input per cycle
// while each input gives at most one response word and rsp_stall is low; an
// input giving several words holds the output stage for each of its words,
// and the queue of QUEUE_DEPTH groups between the decoder and the serialiser
// absorbs the difference. req_stall rises only when that queue is full.
// Reset (synchronous, active high) returns the decoder to idle, empties the
// queue and drops any response word not yet taken. While rsp_stall is high
// the response word holds, the queue fills and then req_stall rises.
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     q_full;
   logic     push;
   grp_type  push_grp;
   logic     pop;
   head_type head;

   // decode and classify one byte per cycle while the queue is not full
   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_grp  (push_grp)
   );

   // buffer groups of up to four words between the two sides
   jsu_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_grp (push_grp),
      .full     (q_full),
      .pop      (pop),
      .head     (head)
   );

   // serialise each group into response words
   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
